>>> design/adu_pkg.sv
`default_nettype none

package adu_pkg;

    localparam int DEPTH_DEF = 4096;
    localparam int ITER      = 64;

    // configuration register indexes
    localparam logic [2:0] REG_BASE_RATE   = 3'd0;
    localparam logic [2:0] REG_RATE_DECAY  = 3'd1;
    localparam logic [2:0] REG_STAB_EPS    = 3'd2;
    localparam logic [2:0] REG_FIRST_BETA  = 3'd3;
    localparam logic [2:0] REG_SECOND_BETA = 3'd4;

    localparam logic [31:0] BASE_RATE_RST = 32'd4294967;
    localparam logic [31:0] EPS_RST       = 32'd430;
    localparam logic [15:0] BETA1_RST     = 16'd58982;
    localparam logic [15:0] BETA2_RST     = 16'd65470;
    localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
    localparam logic [34:0] STEP_MAX      = 35'h4_0000_0000;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RATE_MUL,
        ST_RATE_ADD,
        ST_RATE_DIV,
        ST_READ,
        ST_MOM_MUL,
        ST_MOM_ADD,
        ST_V_DECAY,
        ST_V_GRAD,
        ST_MHAT,
        ST_VHAT,
        ST_ROOT,
        ST_SCALE,
        ST_STEP,
        ST_APPLY,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> design/adam_parameter_update.sv
// Adam parameter update engine.
// Input stream (s_axis): one beat per trainable value carrying its index,
// current value and gradient; tlast marks the last value of an update pass.
// Output stream (m_axis): one beat per input beat, in order, with the index,
// the updated and saturated value, and tlast echoed.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// learning rate, decay, epsilon and the two betas; it is always ready.
// Each beat is worked bit-serially by one shared multiply/divide/root unit:
// two moment products, two bias-correction divides, one square root, the
// rate product and the step divide. A beat whose index lies beyond the
// moment memories passes its value through without these steps.
// A beat with tlast set, and a write of the rate or the decay, is followed
// by a rate recompute before the next beat is accepted.
// One beat is worked at a time; the next is accepted as soon as the result
// sits in the output register, even while the receiver holds tready low.
// After reset the block sweeps both moment memories to zero, one entry a
// cycle with s_axis_tready low. A stalled receiver holds the result; a second
// result waits until the output register empties.
`default_nettype none

module adam_parameter_update import adu_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // elem_index[11:0], param_value[43:12],
                                       // grad_value[75:44], zero pad[79:76]
    input  logic        s_axis_tlast,  // pass_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_index[11:0], new_value[43:12],
                                       // zero pad[47:44]
    output logic        m_axis_tlast,  // out_pass_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);

    state_t state_reg, state_next;

    // configuration and pass state
    logic [31:0] base_rate_reg, rate_decay_reg, eps_reg;
    logic [15:0] first_beta_reg, second_beta_reg;
    logic [31:0] pass_count_reg;
    logic [32:0] beta1_power_reg, beta2_power_reg;
    logic [32:0] pw1_reg, pw2_reg;
    logic [31:0] active_rate_reg;
    logic        pend_reg, pend_next;
    logic        launched_reg, launched_next;
    logic [AW-1:0] clr_reg;

    // item datapath
    logic [11:0]  idx_reg;
    logic [31:0]  p_reg, g_reg;
    logic         last_reg, idx_ok_reg;
    logic         msign_reg;
    logic [47:0]  mmag_reg;
    logic [31:0]  gmag_reg;
    logic [63:0]  v_reg, va_reg;
    logic [63:0]  scaled_reg, g2_reg;
    logic signed [49:0] gterm_reg;
    logic [47:0]  m_reg;
    logic [63:0]  mhat_reg, vhat_reg, den_reg, step_reg;
    logic [111:0] scale_reg;
    logic [31:0]  result_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_index_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    // arithmetic unit link
    arith_req_t   arith_req;
    arith_stat_t  arith_stat;
    logic [127:0] arith_a;
    logic [63:0]  arith_b;
    logic [127:0] arith_res;
    logic         is_arith;

    // memories
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [47:0]   mem_m_wdata, mem_m_rdata;
    logic [63:0]   mem_v_wdata, mem_v_rdata;

    // combinational helpers
    logic        accept, out_free, leave;
    logic [47:0] m_rd_abs, m_abs;
    logic [31:0] g_abs;
    logic [16:0] b1c, b2c;
    logic [63:0] mom_prod, g2_prod, rate_prod;
    logic signed [49:0] gterm_prod;
    logic [48:0] pw1_prod, pw2_prod;
    logic [49:0] part_ext, m_sum;
    logic [64:0] den_sum;
    logic [34:0] step_lim, step_use;
    logic signed [36:0] p_ext, s_ext, upd;
    logic [31:0] upd_sat, result_val;
    logic        m_pos;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign leave    = (state_reg == ST_OUT) && out_free;
    assign cfg_ready = 1'b1;

    assign b1c = 17'd65536 - {1'b0, first_beta_reg};
    assign b2c = 17'd65536 - {1'b0, second_beta_reg};

    assign m_rd_abs   = mem_m_rdata[47] ? (~mem_m_rdata + 48'd1) : mem_m_rdata;
    assign m_abs      = m_reg[47] ? (~m_reg + 48'd1) : m_reg;
    assign g_abs      = g_reg[31] ? (~g_reg + 32'd1) : g_reg;
    assign mom_prod   = mmag_reg * first_beta_reg;
    assign g2_prod    = gmag_reg * gmag_reg;
    assign gterm_prod = $signed({1'b0, b1c}) * $signed(g_reg);
    assign pw1_prod   = beta1_power_reg * first_beta_reg;
    assign pw2_prod   = beta2_power_reg * second_beta_reg;
    assign rate_prod  = rate_decay_reg * pass_count_reg;
    assign den_sum    = {1'b0, den_reg} + 65'd65536;

    // restore the sign of b1*m, then add the gradient share
    assign part_ext = msign_reg ? (~{2'b00, scaled_reg[63:16]} + 50'd1)
                                : {2'b00, scaled_reg[63:16]};
    assign m_sum    = part_ext + gterm_reg;

    // clamp the step, drop it on a zero numerator or denominator
    assign step_lim = (step_reg > {29'b0, STEP_MAX}) ? STEP_MAX : step_reg[34:0];
    assign step_use = (den_reg == 64'd0 || mhat_reg == 64'd0) ? 35'd0 : step_lim;
    assign m_pos    = !m_reg[47] && (m_reg != 48'd0);
    assign p_ext    = {{5{p_reg[31]}}, p_reg};
    assign s_ext    = {2'b00, step_use};
    always_comb
    begin
        if (m_pos)
        begin
            upd = p_ext - s_ext;
        end
        else if (m_reg[47])
        begin
            upd = p_ext + s_ext;
        end
        else
        begin
            upd = p_ext;
        end
    end
    assign upd_sat = (upd[36:31] == 6'b000000 || upd[36:31] == 6'b111111) ? upd[31:0] :
                     (upd[36] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign result_val = idx_ok_reg ? upd_sat : p_reg;

    assign is_arith = (state_reg == ST_RATE_DIV) || (state_reg == ST_V_DECAY) ||
                      (state_reg == ST_V_GRAD) || (state_reg == ST_MHAT) ||
                      (state_reg == ST_VHAT) || (state_reg == ST_ROOT) ||
                      (state_reg == ST_SCALE) || (state_reg == ST_STEP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    state_next = ST_RATE_MUL;
                end
                else if (s_axis_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_RATE_MUL: state_next = ST_RATE_ADD;
            ST_RATE_ADD: state_next = ST_RATE_DIV;
            ST_RATE_DIV: if (arith_stat.done) state_next = ST_IDLE;
            ST_READ:     state_next = idx_ok_reg ? ST_MOM_MUL : ST_APPLY;
            ST_MOM_MUL:  state_next = ST_MOM_ADD;
            ST_MOM_ADD:  state_next = ST_V_DECAY;
            ST_V_DECAY:  if (arith_stat.done) state_next = ST_V_GRAD;
            ST_V_GRAD:   if (arith_stat.done) state_next = ST_MHAT;
            ST_MHAT:     if (arith_stat.done) state_next = ST_VHAT;
            ST_VHAT:     if (arith_stat.done) state_next = ST_ROOT;
            ST_ROOT:     if (arith_stat.done) state_next = ST_SCALE;
            ST_SCALE:    if (arith_stat.done) state_next = ST_STEP;
            ST_STEP:     if (arith_stat.done) state_next = ST_APPLY;
            ST_APPLY:    state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake, operand selection, memory control
    always_comb
    begin
        s_axis_tready   = (state_reg == ST_IDLE) && !pend_reg;
        arith_req.start = is_arith && !launched_reg;
        launched_next   = is_arith && !arith_stat.done;
        arith_req.op    = OP_MUL;
        arith_a         = '0;
        arith_b         = '0;
        case (state_reg)
            ST_RATE_DIV:
            begin
                arith_req.op = OP_DIV;
                arith_a      = {80'b0, base_rate_reg, 16'b0};
                arith_b      = den_reg;
            end
            ST_V_DECAY:
            begin
                arith_a = {64'b0, v_reg};
                arith_b = {48'b0, second_beta_reg};
            end
            ST_V_GRAD:
            begin
                arith_a = {64'b0, g2_reg};
                arith_b = {47'b0, b2c};
            end
            ST_MHAT:
            begin
                arith_req.op = OP_DIV;
                arith_a      = {48'b0, m_abs, 32'b0};
                arith_b      = {31'b0, ONE_Q32 - pw1_reg};
            end
            ST_VHAT:
            begin
                arith_req.op = OP_DIV;
                arith_a      = {32'b0, v_reg, 32'b0};
                arith_b      = {31'b0, ONE_Q32 - pw2_reg};
            end
            ST_ROOT:
            begin
                arith_req.op = OP_SQRT;
                arith_a      = {32'b0, vhat_reg, 32'b0};
            end
            ST_SCALE:
            begin
                arith_a = {64'b0, mhat_reg};
                arith_b = {32'b0, active_rate_reg};
            end
            ST_STEP:
            begin
                arith_req.op = OP_DIV;
                arith_a      = {16'b0, scale_reg};
                arith_b      = den_reg;
            end
            default:
            begin
                arith_req.op = OP_MUL;
            end
        endcase
        mem_we      = (state_reg == ST_CLEAR) || ((state_reg == ST_APPLY) && idx_ok_reg);
        mem_waddr   = (state_reg == ST_CLEAR) ? clr_reg : AW'(idx_reg);
        mem_m_wdata = (state_reg == ST_CLEAR) ? 48'd0 : m_reg;
        mem_v_wdata = (state_reg == ST_CLEAR) ? 64'd0 : v_reg;
        mem_raddr   = (state_reg == ST_IDLE) ? AW'(s_axis_tdata[11:0]) : AW'(idx_reg);
    end

    // pending rate recompute: set by rate writes and pass ends
    always_comb
    begin
        pend_next = pend_reg;
        if ((state_reg == ST_IDLE) && pend_reg)
        begin
            pend_next = 1'b0;
        end
        if (cfg_valid && cfg_ready &&
            (cfg_index == REG_BASE_RATE || cfg_index == REG_RATE_DECAY))
        begin
            pend_next = 1'b1;
        end
        if (leave && last_reg)
        begin
            pend_next = 1'b1;
        end
    end

    assign out_valid_next = leave ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            pend_reg        <= 1'b0;
            launched_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            base_rate_reg   <= BASE_RATE_RST;
            rate_decay_reg  <= 32'd0;
            eps_reg         <= EPS_RST;
            first_beta_reg  <= BETA1_RST;
            second_beta_reg <= BETA2_RST;
            pass_count_reg  <= 32'd0;
            beta1_power_reg <= ONE_Q32;
            beta2_power_reg <= ONE_Q32;
            active_rate_reg <= BASE_RATE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_RATE:   base_rate_reg   <= cfg_data;
                    REG_RATE_DECAY:  rate_decay_reg  <= cfg_data;
                    REG_STAB_EPS:    eps_reg         <= cfg_data;
                    REG_FIRST_BETA:  first_beta_reg  <= cfg_data[15:0];
                    REG_SECOND_BETA: second_beta_reg <= cfg_data[15:0];
                    default:         ;
                endcase
            end
            // advance the pass: count, beta powers
            if (leave && last_reg)
            begin
                if (pass_count_reg != 32'hFFFF_FFFF)
                begin
                    pass_count_reg <= pass_count_reg + 32'd1;
                end
                beta1_power_reg <= pw1_reg;
                beta2_power_reg <= pw2_reg;
            end
            if ((state_reg == ST_RATE_DIV) && arith_stat.done)
            begin
                active_rate_reg <= arith_res[31:0];
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        pw1_reg <= pw1_prod[48:16];
        pw2_reg <= pw2_prod[48:16];
        if (accept)
        begin
            idx_reg    <= s_axis_tdata[11:0];
            p_reg      <= s_axis_tdata[43:12];
            g_reg      <= s_axis_tdata[75:44];
            last_reg   <= s_axis_tlast;
            idx_ok_reg <= (32'(s_axis_tdata[11:0]) < DEPTH);
        end
        case (state_reg)
            ST_RATE_MUL:
            begin
                den_reg <= rate_prod;
            end
            ST_RATE_ADD:
            begin
                den_reg <= den_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : den_sum[63:0];
            end
            ST_READ:
            begin
                msign_reg <= mem_m_rdata[47];
                mmag_reg  <= m_rd_abs;
                v_reg     <= mem_v_rdata;
                gmag_reg  <= g_abs;
            end
            ST_MOM_MUL:
            begin
                scaled_reg <= mom_prod;
                gterm_reg  <= gterm_prod;
                g2_reg     <= g2_prod;
            end
            ST_MOM_ADD:
            begin
                m_reg <= m_sum[47:0];
            end
            ST_V_DECAY:
            begin
                if (arith_stat.done) va_reg <= arith_res[79:16];
            end
            ST_V_GRAD:
            begin
                if (arith_stat.done) v_reg <= va_reg + arith_res[79:16];
            end
            ST_MHAT:
            begin
                if (arith_stat.done) mhat_reg <= arith_res[63:0];
            end
            ST_VHAT:
            begin
                if (arith_stat.done) vhat_reg <= arith_res[63:0];
            end
            ST_ROOT:
            begin
                if (arith_stat.done) den_reg <= arith_res[63:0] + {32'b0, eps_reg};
            end
            ST_SCALE:
            begin
                if (arith_stat.done) scale_reg <= arith_res[127:16];
            end
            ST_STEP:
            begin
                if (arith_stat.done) step_reg <= arith_res[63:0];
            end
            ST_APPLY:
            begin
                result_reg <= result_val;
            end
            default:
            begin
            end
        endcase
        if (leave)
        begin
            out_index_reg <= idx_reg;
            out_value_reg <= result_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_value_reg, out_index_reg};
    assign m_axis_tlast  = out_last_reg;

    adu_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .a      (arith_a),
        .b      (arith_b),
        .stat   (arith_stat),
        .result (arith_res)
    );

    adu_ram #(
        .WIDTH (48),
        .DEPTH (DEPTH)
    ) u_mem_m (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_m_wdata),
        .raddr (mem_raddr),
        .rdata (mem_m_rdata)
    );

    adu_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_mem_v (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_v_wdata),
        .raddr (mem_raddr),
        .rdata (mem_v_rdata)
    );

`ifndef SYNTH
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        arith_req.start |-> !arith_stat.busy)
        else $error("arith unit launched while busy");
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_axis_tready)
        else $error("beat accepted during memory sweep");
    a_pass_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> pass_count_reg >= $past(pass_count_reg))
        else $error("pass count went backward");
    a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
        beta1_power_reg <= ONE_Q32 && beta2_power_reg <= ONE_Q32)
        else $error("beta power above one");
`endif

endmodule

`default_nettype wire

>>> design/adu_ram.sv
`default_nettype none

module adu_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/adu_arith.sv
`default_nettype none

// Bit-serial multiply, divide and square root, one multiplier bit or one quotient or root bit per cycle.
module adu_arith import adu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  arith_req_t  req,
    input  logic [127:0] a,
    input  logic [63:0] b,
    output arith_stat_t stat,
    output logic [127:0] result
);

    arith_op_t    op_reg, op_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] sh_reg, sh_next;
    logic [63:0]  q_reg, q_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  d_reg, d_next;
    logic [64:0]  div_rem;
    logic [67:0]  sq_rem;
    logic [67:0]  sq_trial;

    assign div_rem  = {acc_reg[63:0], sh_reg[127]};
    assign sq_rem   = {acc_reg[65:0], sh_reg[127:126]};
    assign sq_trial = {2'b00, q_reg, 2'b01};

    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        a_next    = a_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = 7'(ITER);
            acc_next  = '0;
            q_next    = '0;
            a_next    = a[63:0];
            d_next    = b;
            case (req.op)
                OP_MUL:
                begin
                    sh_next = {b, 64'b0};
                end
                OP_DIV:
                begin
                    sh_next  = {a[63:0], 64'b0};
                    acc_next = {64'b0, a[127:64]};
                    // quotient would not fit: saturate at once
                    if (a[127:64] >= b)
                    begin
                        q_next    = '1;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    sh_next = a;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    sh_next  = sh_reg << 1;
                    acc_next = (acc_reg << 1) + (sh_reg[127] ? {64'b0, a_reg} : 128'b0);
                end
                OP_DIV:
                begin
                    sh_next = sh_reg << 1;
                    if (div_rem >= {1'b0, d_reg})
                    begin
                        acc_next = {64'b0, 64'(div_rem - {1'b0, d_reg})};
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {64'b0, div_rem[63:0]};
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    sh_next = sh_reg << 2;
                    if (sq_rem >= sq_trial)
                    begin
                        acc_next = {60'b0, sq_rem - sq_trial};
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {60'b0, sq_rem};
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        a_reg   <= a_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == OP_MUL) ? acc_reg : {64'b0, q_reg};

endmodule

`default_nettype wire

>>> tb/tb_adam_parameter_update.sv
`default_nettype none

module tb_adam_parameter_update import adu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IDX_MAX     = 4095;
    localparam int  SETTLE      = 600;
    localparam int  HOLD_CYCLES = 3000;
    localparam longint LIMIT    = 2000000;

    typedef struct {
        logic [11:0] idx;
        logic [31:0] value;
        logic [31:0] grad;
        logic        last;
    } elem_t;

    typedef struct {
        logic [11:0] idx;
        logic [31:0] value;
        logic        last;
    } update_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // elem_index[11:0], param_value[43:12],
                                 // grad_value[75:44], zero pad[79:76]
    logic        s_axis_tlast;   // pass_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_index[11:0], new_value[43:12],
                                 // zero pad[47:44]
    logic        m_axis_tlast;   // out_pass_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    adam_parameter_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow of the block's registers and state
    logic [63:0] base_rate, rate_decay, stab_eps, beta1, beta2;
    longint      m_mem [0:IDX_MAX];
    logic [63:0] v_mem [0:IDX_MAX];
    logic [63:0] passes, b1_pow, b2_pow, cur_rate;

    elem_t   pending_beats [$];
    update_t due_updates [$];

    int     errors;
    int     beats_queued;
    int     beats_in;
    int     beats_out;
    int     pass_ends;
    int     cfg_writes;
    longint cycles;
    bit     no_idle;      // run both sides without gaps
    bit     hold_phase;   // ask the receiver for its long hold-off
    bit     hold_done;
    int     hold_cnt;

    // clock; the single reset at start comes from the stimulus block
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -------------------------------------------------------------------
    // arithmetic helpers
    // -------------------------------------------------------------------

    // quotient saturated to 64 bits
    function automatic logic [63:0] sat_div(input logic [127:0] num, input logic [63:0] d);
        logic [127:0] q;
        if (num[127:64] >= d)
            return '1;
        q = num / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= x)
                r = c;
        end
        return r;
    endfunction

    // rate = base/(1 + decay*passes), denominator in Q16.16
    function automatic void refresh_rate();
        logic [63:0] den;
        den = 64'd65536;
        if (rate_decay != 0)
        begin
            if (passes > (64'hFFFF_FFFF_FFFF_FFFF - 64'd65536) / rate_decay)
                den = '1;
            else
                den = 64'd65536 + rate_decay * passes;
        end
        cur_rate = (base_rate << 16) / den;
    endfunction

    function automatic void apply_cfg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_BASE_RATE:   begin base_rate  = {32'd0, data}; refresh_rate(); end
            REG_RATE_DECAY:  begin rate_decay = {32'd0, data}; refresh_rate(); end
            REG_STAB_EPS:    stab_eps = {32'd0, data};
            REG_FIRST_BETA:  beta1 = {48'd0, data[15:0]};
            REG_SECOND_BETA: beta2 = {48'd0, data[15:0]};
            default: ;
        endcase
    endfunction

    // one Adam step on the shadow state; returns the updated value beat
    function automatic update_t adam_step(input elem_t e);
        update_t      u;
        longint       p, g, m, part, res;
        logic [63:0]  pw1, pw2, c1, c2, v, mmag, gmag, g2, scaled;
        logic [63:0]  mhat, vhat, root, den, step;
        logic [127:0] wide;
        p    = longint'(signed'(e.value));
        g    = longint'(signed'(e.grad));
        pw1  = (b1_pow * beta1) >> 16;
        pw2  = (b2_pow * beta2) >> 16;
        c1   = (64'd1 << 32) - pw1;
        c2   = (64'd1 << 32) - pw2;
        m    = m_mem[e.idx];
        v    = v_mem[e.idx];
        // moments: decay toward zero, then add the gradient share
        mmag   = (m < 0) ? -m : m;
        scaled = (mmag * beta1) >> 16;
        part   = (m < 0) ? -longint'(scaled) : longint'(scaled);
        gmag   = (g < 0) ? -g : g;
        g2     = gmag * gmag;
        m      = part + longint'(64'd65536 - beta1) * g;
        wide   = ({64'd0, v} * {64'd0, beta2}) >> 16;
        v      = wide[63:0];
        wide   = ({64'd0, g2} * {64'd0, 64'd65536 - beta2}) >> 16;
        v      = v + wide[63:0];
        m_mem[e.idx] = m;
        v_mem[e.idx] = v;
        // bias correction, root and step
        mmag = (m < 0) ? -m : m;
        mhat = sat_div({64'd0, mmag} << 32, c1);
        vhat = sat_div({64'd0, v} << 32, c2);
        root = floor_root({64'd0, vhat} << 32);
        den  = root + stab_eps;
        step = '0;
        if (den != 0 && mhat != 0)
        begin
            wide = ({64'd0, cur_rate} * {64'd0, mhat}) >> 16;
            step = sat_div(wide, den);
        end
        if (step > {29'd0, STEP_MAX})
            step = {29'd0, STEP_MAX};
        res = p;
        if (m > 0)
            res = p - longint'(step);
        else if (m < 0)
            res = p + longint'(step);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        // pass end advances the powers and the rate after this update
        if (e.last)
        begin
            if (passes < 64'hFFFF_FFFF)
                passes++;
            b1_pow = pw1;
            b2_pow = pw2;
            refresh_rate();
        end
        u.idx   = e.idx;
        u.value = res[31:0];
        u.last  = e.last;
        return u;
    endfunction

    // -------------------------------------------------------------------
    // driver: feed pending beats, predict each accepted beat
    // -------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        elem_t e;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                e.idx   = s_axis_tdata[11:0];
                e.value = s_axis_tdata[43:12];
                e.grad  = s_axis_tdata[75:44];
                e.last  = s_axis_tlast;
                due_updates.push_back(adam_step(e));
                beats_in++;
                if (e.last)
                    pass_ends++;
            end
            // advance only when the slot is empty or just taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 17))
                begin
                    e = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, e.grad, e.value, e.idx};
                    s_axis_tlast  <= e.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // monitor: stall at random, hold off once, check each result beat
    // -------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        update_t u;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_out++;
                if (due_updates.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat idx=%0d value=%h last=%0b",
                             $time, m_axis_tdata[11:0], m_axis_tdata[43:12], m_axis_tlast);
                end
                else
                begin
                    u = due_updates.pop_front();
                    if (m_axis_tdata[11:0] !== u.idx)
                    begin
                        errors++;
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, u.idx, m_axis_tdata[11:0]);
                    end
                    if (m_axis_tdata[43:12] !== u.value)
                    begin
                        errors++;
                        $display("%0t: new_value idx %0d expected %h actual %h",
                                 $time, u.idx, u.value, m_axis_tdata[43:12]);
                    end
                    if (m_axis_tlast !== u.last)
                    begin
                        errors++;
                        $display("%0t: out_pass_end idx %0d expected %0b actual %0b",
                                 $time, u.idx, u.last, m_axis_tlast);
                    end
                end
            end
            // long hold-off so the block fills and stalls its input
            if (hold_phase && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt      <= hold_cnt + 1;
                if (hold_cnt == HOLD_CYCLES)
                    hold_done <= 1'b1;
            end
            else
            begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    // mirror register writes into the shadow at the handshake
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            apply_cfg(cfg_index, cfg_data);
            cfg_writes++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, due_updates.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued beat has come back, then let a recompute finish
    task automatic drain();
        while (beats_out < beats_queued)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_beat(input int idx, input logic [31:0] value,
                             input logic [31:0] grad, input bit last);
        elem_t e;
        e.idx   = idx[11:0];
        e.value = value;
        e.grad  = grad;
        e.last  = last;
        pending_beats.push_back(e);
        beats_queued++;
    endtask

    // mostly passes over a small set of indices, so moments build up
    task automatic random_beats(input int count);
        logic [31:0] val, grad;
        int idx;
        for (int i = 0; i < count; i++)
        begin
            idx  = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(IDX_MAX);
            val  = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0004_0000)
                                                           - 32'h0002_0000;
            case ($urandom_range(3))
                0:       grad = $urandom();
                1:       grad = $urandom_range(32'h0000_2000) - 32'h0000_1000;
                default: grad = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            endcase
            push_beat(idx, val, grad, $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        errors       = 0;
        beats_queued = 0;
        beats_in     = 0;
        beats_out    = 0;
        pass_ends    = 0;
        cfg_writes   = 0;
        cycles       = 0;
        no_idle      = 1'b0;
        hold_phase   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        base_rate    = {32'd0, BASE_RATE_RST};
        rate_decay   = '0;
        stab_eps     = {32'd0, EPS_RST};
        beta1        = {48'd0, BETA1_RST};
        beta2        = {48'd0, BETA2_RST};
        passes       = '0;
        b1_pow       = {31'd0, ONE_Q32};
        b2_pow       = {31'd0, ONE_Q32};
        cur_rate     = base_rate;
        for (int i = 0; i <= IDX_MAX; i++)
        begin
            m_mem[i] = 0;
            v_mem[i] = '0;
        end
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // hold until the memory sweep is over
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);

        // directed: reset settings, field extremes, repeated index, pass ends
        push_beat(0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        push_beat(0, 32'h0001_0000, 32'h0001_0000, 1'b1);
        push_beat(0, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
        push_beat(IDX_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_beat(IDX_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        push_beat(1, 32'h8000_0000, 32'h0000_0000, 1'b0);
        push_beat(2, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        push_beat(3, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        drain();

        // extremes: full rate, no epsilon, zero first beta, top second beta
        write_reg(REG_BASE_RATE, 32'hFFFF_FFFF);
        write_reg(REG_STAB_EPS, 32'h0000_0000);
        write_reg(REG_FIRST_BETA, 32'hFFFF_0000);   // masks to zero
        write_reg(REG_SECOND_BETA, 32'h0000_FFFF);
        write_reg(3'd5, 32'h1234_5678);             // beyond the list: ignored
        push_beat(4, 32'h7FFF_0000, 32'h7FFF_FFFF, 1'b0);
        push_beat(4, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push_beat(5, 32'h0000_0000, 32'h0000_0000, 1'b0);  // zero denominator
        push_beat(5, 32'h0000_1000, 32'h0000_0000, 1'b1);
        drain();

        // extremes: top first beta, zero second beta, max decay, tiny rate
        write_reg(REG_FIRST_BETA, 32'h0000_FFFF);
        write_reg(REG_SECOND_BETA, 32'h0000_0000);
        write_reg(REG_RATE_DECAY, 32'hFFFF_FFFF);
        write_reg(REG_STAB_EPS, 32'hFFFF_FFFF);
        write_reg(REG_BASE_RATE, 32'h0000_0001);
        write_reg(3'd7, 32'hFFFF_FFFF);
        push_beat(6, 32'h0010_0000, 32'h0000_8000, 1'b1);
        push_beat(6, 32'hFFF0_0000, 32'hFFFF_8000, 1'b1);
        push_beat(7, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        push_beat(0, 32'h0000_0000, 32'h0001_0000, 1'b0);
        drain();

        // back to typical settings, no idling on either side
        write_reg(REG_BASE_RATE, 32'd42949673);
        write_reg(REG_RATE_DECAY, 32'h0000_1000);
        write_reg(REG_STAB_EPS, 32'd430);
        write_reg(REG_FIRST_BETA, 32'd58982);
        write_reg(REG_SECOND_BETA, 32'd65470);
        no_idle = 1'b1;
        random_beats(100);
        drain();
        no_idle = 1'b0;

        // receiver holds off while the sender keeps offering
        hold_phase = 1'b1;
        random_beats(100);
        drain();

        // several random settings
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_BASE_RATE, $urandom());
            write_reg(REG_RATE_DECAY,
                      ($urandom_range(1) == 0) ? 32'd0 : $urandom_range(32'h0002_0000));
            write_reg(REG_STAB_EPS, $urandom_range(32'h0001_0000));
            write_reg(REG_FIRST_BETA, $urandom());
            write_reg(REG_SECOND_BETA, $urandom());
            write_reg(3'd6, $urandom());
            random_beats(60);
            drain();
        end

        $display("covered %0d value beats, %0d results, %0d pass ends, %0d register writes",
                 beats_in, beats_out, pass_ends, cfg_writes);
        $display("settings swept from reset values through both beta and rate extremes");
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/adu_pkg.sv
design/adu_ram.sv
design/adu_arith.sv
design/adam_parameter_update.sv
tb/tb_adam_parameter_update.sv
